// ===== design/coapmp_pkg.sv =====
// ----------------------------------------------------------------------------
// CoAP message parser package
// Types and codes shared by the CoAP byte parser: parse phases, event codes
// reported with each byte, and option kinds.
// ----------------------------------------------------------------------------
package coapmp_pkg;

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_TOKEN   = 6'b000010,
        PH_OPTION  = 6'b000100,
        PH_EXT     = 6'b001000,
        PH_VALUE   = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    typedef logic [2:0] event_t;
    localparam event_t EV_NONE      = 3'd0;
    localparam event_t EV_HEADER    = 3'd1;
    localparam event_t EV_TOKEN     = 3'd2;
    localparam event_t EV_OPT_HEAD  = 3'd3;
    localparam event_t EV_OPT_VALUE = 3'd4;
    localparam event_t EV_PAYLOAD   = 3'd5;
    localparam event_t EV_END       = 3'd6;
    localparam event_t EV_TRUNC     = 3'd7;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_OTHER    = 2'd0;
    localparam kind_t KIND_LOCATION = 2'd1;
    localparam kind_t KIND_URI      = 2'd2;
    localparam kind_t KIND_OBSERVE  = 2'd3;

    localparam logic [7:0] OPT_NUM_OBSERVE  = 8'd6;
    localparam logic [7:0] OPT_NUM_LOCATION = 8'd8;
    localparam logic [7:0] OPT_NUM_URI      = 8'd11;

    localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
    localparam logic [3:0] LEN_EXT_BYTE   = 4'd13;

    // Flag bit positions in the found-flags summary.
    localparam int FLAG_LOCATION = 0;
    localparam int FLAG_URI      = 1;
    localparam int FLAG_OBSERVE  = 2;
    localparam int FLAG_PAYLOAD  = 3;

    function automatic kind_t kind_of(input logic [7:0] num);
        kind_t k;
        k = KIND_OTHER;
        if (num == OPT_NUM_LOCATION)
        begin
            k = KIND_LOCATION;
        end
        else if (num == OPT_NUM_URI)
        begin
            k = KIND_URI;
        end
        else if (num == OPT_NUM_OBSERVE)
        begin
            k = KIND_OBSERVE;
        end
        return k;
    endfunction

endpackage

// ===== design/coap_message_byte_parser.sv =====
// ----------------------------------------------------------------------------
// CoAP message byte parser
// Parses one datagram byte per item: fixed header, token, options and
// payload, reporting the role of every byte and the header fields so far.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+--------------------------------
//  in      | input     | in_valid/in_stall  | data_byte, last_byte
//  out     | output    | out_valid/out_stall| event_res, header fields,
//          |           |                    | option fields, data_out, flags
//
//  Every byte yields one result item in the cycle after it is accepted; a new
//  byte can be taken in every cycle without in_stall, set by the single state update.
//  Reset clears the parse state and empties the result register.
//  The input stalls only while a result is held and the output stalls.
//  A byte flagged as last returns the parse state to its reset value.
//
module coap_message_byte_parser #(
    parameter int MAX_PATH_SEGMENTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [1:0]  msg_type,
    output logic [3:0]  token_length,
    output logic [2:0]  msg_class,
    output logic [4:0]  msg_detail,
    output logic [15:0] msg_id,
    output logic [7:0]  option_number,
    output logic [8:0]  option_length,
    output logic [1:0]  option_kind,
    output logic [7:0]  data_out,
    output logic [3:0]  segment_index,
    output logic [3:0]  found_flags
);
    import coapmp_pkg::*;

    localparam logic [3:0] SEG_MAX = 4'(MAX_PATH_SEGMENTS);

    // Parse state.
    phase_t      phase_reg,   phase_next;
    logic [1:0]  hpos_reg,    hpos_next;
    logic [29:0] header_reg,  header_next;
    logic [3:0]  tok_rem_reg, tok_rem_next;
    logic [7:0]  opt_sum_reg, opt_sum_next;
    logic [8:0]  val_rem_reg, val_rem_next;
    kind_t       kind_reg,    kind_next;
    logic [3:0]  seg_reg,     seg_next;
    logic [3:0]  flags_reg,   flags_next;

    // Result register.
    logic        out_valid_reg;
    event_t      event_reg,   event_next;
    logic [29:0] res_hdr_reg;
    logic [7:0]  res_sum_reg;
    logic [8:0]  res_len_reg;
    kind_t       res_kind_reg;
    logic [7:0]  res_data_reg, data_next;
    logic [3:0]  res_seg_reg;
    logic [3:0]  res_flags_reg;

    logic accept;
    logic marker;
    logic head_done;
    logic incomplete;
    logic [7:0] sum_add;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign sum_add  = opt_sum_reg + {4'd0, data_byte[7:4]};

    always_comb
    begin
        phase_next   = phase_reg;
        hpos_next    = hpos_reg;
        header_next  = header_reg;
        tok_rem_next = tok_rem_reg;
        opt_sum_next = opt_sum_reg;
        val_rem_next = val_rem_reg;
        kind_next    = kind_reg;
        seg_next     = seg_reg;
        flags_next   = flags_reg;
        event_next   = EV_NONE;
        data_next    = 8'd0;
        marker       = 1'b0;
        head_done    = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                unique case (hpos_reg)
                    2'd0:    header_next = {data_byte[5:4], data_byte[3:0], 24'd0};
                    2'd1:    header_next[23:16] = data_byte;
                    2'd2:    header_next[15:8] = data_byte;
                    default:
                    begin
                        header_next[7:0] = data_byte;
                        event_next       = EV_HEADER;
                        tok_rem_next     = header_reg[27:24];
                        phase_next       = (header_reg[27:24] != 4'd0) ? PH_TOKEN
                                                                       : PH_OPTION;
                    end
                endcase
                hpos_next = hpos_reg + 2'd1;
            end
            PH_TOKEN:
            begin
                event_next   = EV_TOKEN;
                data_next    = data_byte;
                tok_rem_next = tok_rem_reg - 4'd1;
                if (tok_rem_reg == 4'd1)
                begin
                    phase_next = PH_OPTION;
                end
            end
            PH_OPTION:
            begin
                if (data_byte == PAYLOAD_MARKER)
                begin
                    flags_next[FLAG_PAYLOAD] = 1'b1;
                    phase_next = PH_PAYLOAD;
                    marker     = 1'b1;
                end
                else
                begin
                    opt_sum_next = sum_add;
                    kind_next    = kind_of(sum_add);
                    val_rem_next = {5'd0, data_byte[3:0]};
                    if (data_byte[3:0] == LEN_EXT_BYTE)
                    begin
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        head_done = 1'b1;
                    end
                end
            end
            PH_EXT:
            begin
                val_rem_next = 9'(LEN_EXT_BYTE) + {1'b0, data_byte};
                head_done    = 1'b1;
            end
            PH_VALUE:
            begin
                event_next   = EV_OPT_VALUE;
                data_next    = data_byte;
                val_rem_next = val_rem_reg - 9'd1;
                if (val_rem_reg == 9'd1)
                begin
                    phase_next = PH_OPTION;
                end
            end
            default:
            begin
                event_next = EV_PAYLOAD;
                data_next  = data_byte;
            end
        endcase

        // A complete option head updates the summary and picks the next phase.
        if (head_done)
        begin
            event_next = EV_OPT_HEAD;
            case (kind_next)
                KIND_LOCATION: flags_next[FLAG_LOCATION] = 1'b1;
                KIND_URI:      flags_next[FLAG_URI]      = 1'b1;
                KIND_OBSERVE:  flags_next[FLAG_OBSERVE]  = 1'b1;
                default:       flags_next = flags_reg;
            endcase
            if ((kind_next == KIND_LOCATION || kind_next == KIND_URI) && seg_reg < SEG_MAX)
            begin
                seg_next = seg_reg + 4'd1;
            end
            phase_next = (val_rem_next != 9'd0) ? PH_VALUE : PH_OPTION;
        end

        incomplete = (phase_next == PH_HEADER) || (phase_next == PH_TOKEN) ||
                     (phase_next == PH_EXT) || (phase_next == PH_VALUE) || marker;
        if (last_byte)
        begin
            event_next = incomplete ? EV_TRUNC : EV_END;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hpos_reg      <= 2'd0;
            header_reg    <= 30'd0;
            tok_rem_reg   <= 4'd0;
            opt_sum_reg   <= 8'd0;
            val_rem_reg   <= 9'd0;
            kind_reg      <= KIND_OTHER;
            seg_reg       <= 4'd0;
            flags_reg     <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                // The final byte of a datagram leaves the parser ready for the next one.
                if (last_byte)
                begin
                    phase_reg   <= PH_HEADER;
                    hpos_reg    <= 2'd0;
                    header_reg  <= 30'd0;
                    tok_rem_reg <= 4'd0;
                    opt_sum_reg <= 8'd0;
                    val_rem_reg <= 9'd0;
                    kind_reg    <= KIND_OTHER;
                    seg_reg     <= 4'd0;
                    flags_reg   <= 4'd0;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    hpos_reg    <= hpos_next;
                    header_reg  <= header_next;
                    tok_rem_reg <= tok_rem_next;
                    opt_sum_reg <= opt_sum_next;
                    val_rem_reg <= val_rem_next;
                    kind_reg    <= kind_next;
                    seg_reg     <= seg_next;
                    flags_reg   <= flags_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_reg     <= event_next;
            res_hdr_reg   <= header_next;
            res_sum_reg   <= opt_sum_next;
            res_len_reg   <= val_rem_next;
            res_kind_reg  <= kind_next;
            res_data_reg  <= data_next;
            res_seg_reg   <= seg_next;
            res_flags_reg <= flags_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = event_reg;
    assign msg_type      = res_hdr_reg[29:28];
    assign token_length  = res_hdr_reg[27:24];
    assign msg_class     = res_hdr_reg[23:21];
    assign msg_detail    = res_hdr_reg[20:16];
    assign msg_id        = res_hdr_reg[15:0];
    assign option_number = res_sum_reg;
    assign option_length = res_len_reg;
    assign option_kind   = res_kind_reg;
    assign data_out      = res_data_reg;
    assign segment_index = res_seg_reg;
    assign found_flags   = res_flags_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// CoAP message byte parser testbench
// Streams datagrams one byte per item into the parser: directed frames
// first, then random well-formed, cut-short and noise datagrams. A byte-level
// parse model predicts the report for every accepted byte, and the monitor
// compares each report field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import coapmp_pkg::*;

    localparam int          SEG_LIMIT    = 8;
    localparam int          ITEM_TARGET  = 1650;
    localparam int          QUIET_FROM   = 700;
    localparam int          QUIET_TO     = 1000;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          SETTLE_TICKS = 8;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;
    } pending_byte_t;

    typedef struct {
        event_t      ev;
        logic [1:0]  mtype;
        logic [3:0]  tkl;
        logic [2:0]  cls;
        logic [4:0]  det;
        logic [15:0] mid;
        logic [7:0]  onum;
        logic [8:0]  olen;
        kind_t       okind;
        logic [7:0]  dout;
        logic [3:0]  seg;
        logic [3:0]  flags;
    } byte_report_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  event_res;
    logic [1:0]  msg_type;
    logic [3:0]  token_length;
    logic [2:0]  msg_class;
    logic [4:0]  msg_detail;
    logic [15:0] msg_id;
    logic [7:0]  option_number;
    logic [8:0]  option_length;
    logic [1:0]  option_kind;
    logic [7:0]  data_out;
    logic [3:0]  segment_index;
    logic [3:0]  found_flags;

    pending_byte_t byte_backlog[$];
    byte_report_t  expected_reports[$];
    byte_report_t  got_expect;

    int unsigned sent_count   = 0;
    int unsigned result_count = 0;
    int unsigned fail_count   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;

    // Parse model state.
    phase_t      ph;
    logic [1:0]  hdr_pos;
    logic [29:0] hdr_word;
    logic [3:0]  tok_left;
    logic [7:0]  opt_sum;
    logic [8:0]  val_left;
    kind_t       cur_kind;
    logic [3:0]  seg_cnt;
    logic [3:0]  flags;

    coap_message_byte_parser #(
        .MAX_PATH_SEGMENTS(SEG_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .msg_type     (msg_type),
        .token_length (token_length),
        .msg_class    (msg_class),
        .msg_detail   (msg_detail),
        .msg_id       (msg_id),
        .option_number(option_number),
        .option_length(option_length),
        .option_kind  (option_kind),
        .data_out     (data_out),
        .segment_index(segment_index),
        .found_flags  (found_flags)
    );

    always #5 clk = ~clk;

    function automatic void clear_parse_state();
        ph       = PH_HEADER;
        hdr_pos  = 2'd0;
        hdr_word = 30'd0;
        tok_left = 4'd0;
        opt_sum  = 8'd0;
        val_left = 9'd0;
        cur_kind = KIND_OTHER;
        seg_cnt  = 4'd0;
        flags    = 4'd0;
    endfunction

    function automatic void close_option_head();
        if (cur_kind == KIND_LOCATION)
            flags[FLAG_LOCATION] = 1'b1;
        else if (cur_kind == KIND_URI)
            flags[FLAG_URI] = 1'b1;
        else if (cur_kind == KIND_OBSERVE)
            flags[FLAG_OBSERVE] = 1'b1;
        if ((cur_kind == KIND_LOCATION || cur_kind == KIND_URI) && seg_cnt < SEG_LIMIT)
            seg_cnt = seg_cnt + 4'd1;
        ph = (val_left != 9'd0) ? PH_VALUE : PH_OPTION;
    endfunction

    function automatic byte_report_t parse_byte(input logic [7:0] b, input logic last);
        byte_report_t r;
        logic         marker;
        logic         incomplete;
        r.ev   = EV_NONE;
        r.dout = 8'd0;
        marker = 1'b0;
        case (ph)
            PH_HEADER:
            begin
                case (hdr_pos)
                    2'd0: hdr_word = {b[5:4], b[3:0], 24'd0};
                    2'd1: hdr_word[23:16] = b;
                    2'd2: hdr_word[15:8] = b;
                    default:
                    begin
                        hdr_word[7:0] = b;
                        r.ev     = EV_HEADER;
                        tok_left = hdr_word[27:24];
                        ph       = (tok_left != 4'd0) ? PH_TOKEN : PH_OPTION;
                    end
                endcase
                hdr_pos = hdr_pos + 2'd1;
            end
            PH_TOKEN:
            begin
                r.ev     = EV_TOKEN;
                r.dout   = b;
                tok_left = tok_left - 4'd1;
                if (tok_left == 4'd0)
                    ph = PH_OPTION;
            end
            PH_OPTION:
            begin
                if (b == PAYLOAD_MARKER)
                begin
                    flags[FLAG_PAYLOAD] = 1'b1;
                    ph     = PH_PAYLOAD;
                    marker = 1'b1;
                end
                else
                begin
                    opt_sum = opt_sum + {4'd0, b[7:4]};
                    case (opt_sum)
                        OPT_NUM_LOCATION: cur_kind = KIND_LOCATION;
                        OPT_NUM_URI:      cur_kind = KIND_URI;
                        OPT_NUM_OBSERVE:  cur_kind = KIND_OBSERVE;
                        default:          cur_kind = KIND_OTHER;
                    endcase
                    val_left = {5'd0, b[3:0]};
                    if (b[3:0] == LEN_EXT_BYTE)
                        ph = PH_EXT;
                    else
                    begin
                        close_option_head();
                        r.ev = EV_OPT_HEAD;
                    end
                end
            end
            PH_EXT:
            begin
                val_left = 9'd13 + {1'b0, b};
                close_option_head();
                r.ev = EV_OPT_HEAD;
            end
            PH_VALUE:
            begin
                r.ev     = EV_OPT_VALUE;
                r.dout   = b;
                val_left = val_left - 9'd1;
                if (val_left == 9'd0)
                    ph = PH_OPTION;
            end
            default:
            begin
                r.ev   = EV_PAYLOAD;
                r.dout = b;
            end
        endcase

        // A bare payload marker at the end counts as a cut-short datagram.
        incomplete = (ph == PH_HEADER) || (ph == PH_TOKEN) || (ph == PH_EXT) ||
                     (ph == PH_VALUE) || marker;
        if (last)
            r.ev = incomplete ? EV_TRUNC : EV_END;

        r.mtype = hdr_word[29:28];
        r.tkl   = hdr_word[27:24];
        r.cls   = hdr_word[23:21];
        r.det   = hdr_word[20:16];
        r.mid   = hdr_word[15:0];
        r.onum  = opt_sum;
        r.olen  = val_left;
        r.okind = cur_kind;
        r.seg   = seg_cnt;
        r.flags = flags;
        if (last)
            clear_parse_state();
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned expv,
                               input int unsigned actv);
        if (expv != actv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            fail_count++;
        end
    endtask

    // Queues the first cut bytes of a frame, the last of them flagged final.
    task automatic queue_frame(input logic [7:0] frame[$], input int unsigned cut,
                               input bit drain);
        pending_byte_t p;
        for (int i = 0; i < cut; i++)
        begin
            p.data  = frame[i];
            p.last  = (i == cut - 1);
            p.drain = drain && (i == 0);
            byte_backlog.push_back(p);
        end
    endtask

    task automatic queue_datagram(input bit drain);
        logic [7:0]  frame[$];
        logic [7:0]  head;
        logic [7:0]  ext;
        logic [7:0]  num;
        logic [7:0]  target;
        logic [3:0]  delta;
        logic [3:0]  len_nib;
        int unsigned tkl;
        int unsigned n_opts;
        int unsigned olen;
        int unsigned plen;
        int unsigned sel;
        int unsigned cut;
        bit          path_heavy;
        bit          long_walk;

        if ($urandom_range(0, 9) == 0)
        begin
            // Noise: random bytes with no structure.
            repeat ($urandom_range(1, 20))
                frame.push_back(8'($urandom));
            queue_frame(frame, frame.size(), drain);
            return;
        end

        tkl = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        head = 8'($urandom);
        head[3:0] = 4'(tkl);
        frame.push_back(head);
        repeat (3)
            frame.push_back(8'($urandom));
        repeat (tkl)
            frame.push_back(8'($urandom));

        sel = $urandom_range(0, 15);
        long_walk  = (sel == 0);
        path_heavy = 1'b0;
        if (long_walk)
            n_opts = $urandom_range(20, 28);
        else if (sel < 3)
        begin
            n_opts     = $urandom_range(9, 14);
            path_heavy = 1'($urandom_range(0, 1));
        end
        else
            n_opts = $urandom_range(0, 5);

        num = 8'd0;
        for (int k = 0; k < n_opts; k++)
        begin
            if (long_walk)
                delta = 4'($urandom_range(8, 15));
            else
            begin
                sel = $urandom_range(0, 9);
                if (path_heavy)
                    target = (num <= OPT_NUM_LOCATION && sel < 4) ? OPT_NUM_LOCATION
                                                                   : OPT_NUM_URI;
                else if (sel < 2)
                    target = OPT_NUM_OBSERVE;
                else if (sel < 4)
                    target = OPT_NUM_LOCATION;
                else if (sel < 6)
                    target = OPT_NUM_URI;
                else
                    target = num + 8'($urandom_range(0, 15));
                if (target >= num && target - num <= 8'd15)
                    delta = 4'(target - num);
                else
                    delta = 4'd0;
            end
            num = num + {4'd0, delta};

            sel = $urandom_range(0, 19);
            if (long_walk || sel < 12)
                len_nib = long_walk ? 4'd0 : 4'($urandom_range(0, 4));
            else if (sel < 15)
                len_nib = 4'($urandom_range(5, 12));
            else if (sel < 17)
                len_nib = LEN_EXT_BYTE;
            else
                len_nib = 4'($urandom_range(14, 15));
            head = {delta, len_nib};
            // Keep the head from reading as the payload marker.
            if (head == PAYLOAD_MARKER)
                head[3:0] = 4'd14;
            frame.push_back(head);
            olen = 32'(head[3:0]);
            if (head[3:0] == LEN_EXT_BYTE)
            begin
                ext = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
                frame.push_back(ext);
                olen = 13 + ext;
            end
            repeat (olen)
                frame.push_back(8'($urandom));
        end

        if ($urandom_range(0, 9) < 7)
        begin
            frame.push_back(PAYLOAD_MARKER);
            plen = $urandom_range(0, 12);
            repeat (plen)
                frame.push_back(8'($urandom));
        end

        cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, frame.size()) : frame.size();
        queue_frame(frame, cut, drain);
    endtask

    // Driver: presents the backlog, idling at random outside the quiet window.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_reports.push_back(parse_byte(data_byte, last_byte));
                sent_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (byte_backlog.size() != 0 &&
                    !(byte_backlog[0].drain && expected_reports.size() != 0) &&
                    !((sent_count < QUIET_FROM || sent_count >= QUIET_TO) &&
                      $urandom_range(0, 99) < 25))
                begin
                    in_valid  <= 1'b1;
                    data_byte <= byte_backlog[0].data;
                    last_byte <= byte_backlog[0].last;
                    void'(byte_backlog.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks every report and drives the output stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report with no byte pending, event_res %0d", event_res);
                    fail_count++;
                end
                else
                begin
                    got_expect = expected_reports.pop_front();
                    check_field("event_res", got_expect.ev, event_res);
                    check_field("msg_type", got_expect.mtype, msg_type);
                    check_field("token_length", got_expect.tkl, token_length);
                    check_field("msg_class", got_expect.cls, msg_class);
                    check_field("msg_detail", got_expect.det, msg_detail);
                    check_field("msg_id", got_expect.mid, msg_id);
                    check_field("option_number", got_expect.onum, option_number);
                    check_field("option_length", got_expect.olen, option_length);
                    check_field("option_kind", got_expect.okind, option_kind);
                    check_field("data_out", got_expect.dout, data_out);
                    check_field("segment_index", got_expect.seg, segment_index);
                    check_field("found_flags", got_expect.flags, found_flags);
                    result_count++;
                end
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (result_count == HOLD_AT && !hold_done)
            begin
                // Long hold-off so the parser backs up and stalls its input.
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (result_count >= QUIET_FROM && result_count < QUIET_TO)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("[coap_message_byte_parser] ERROR");
        $finish;
    end

    initial
    begin
        logic [7:0] frame[$];
        int unsigned n_frames;

        clear_parse_state();

        // Zero header ending cleanly, then an all-ones header cut before its token.
        frame = '{8'h00, 8'h00, 8'h00, 8'h00};
        queue_frame(frame, frame.size(), 1'b0);
        frame = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        queue_frame(frame, frame.size(), 1'b0);
        // Observe, location path, then a uri path head cut before its extended length byte.
        frame = '{8'h50, 8'h45, 8'hBE, 8'hEF, 8'h61, 8'h05, 8'h21, 8'h7A, 8'h3D};
        queue_frame(frame, frame.size(), 1'b0);
        // Payload after the marker, then a marker with no payload.
        frame = '{8'h40, 8'h02, 8'h00, 8'h07, 8'hFF, 8'h55};
        queue_frame(frame, frame.size(), 1'b0);
        frame = '{8'h40, 8'h00, 8'h00, 8'h00, 8'hFF};
        queue_frame(frame, frame.size(), 1'b0);

        n_frames = 0;
        while (byte_backlog.size() < ITEM_TARGET)
        begin
            queue_datagram(n_frames % 25 == 12);
            n_frames++;
        end

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (byte_backlog.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS)
            @(posedge clk);

        if (fail_count == 0)
            $display("[coap_message_byte_parser] OK");
        else
            $display("[coap_message_byte_parser] ERROR");
        $finish;
    end

endmodule
